### hdl/tud_pkg.sv
package tud_pkg;

   localparam int MAX_OUT_LEN = 256;
   localparam int CNT_W       = $clog2(MAX_OUT_LEN);

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] RUN_BASE     = 8'd128;
   localparam logic [7:0] WORD_FIRST   = 8'd247;
   localparam logic [7:0] WORD_LAST    = 8'd255;

   typedef struct packed {
      logic take;
      logic emit;
   } tud_cmd_type;

   typedef struct packed {
      logic has_output;
      logic last_result;
   } tud_stat_type;

   function automatic logic [3:0] word_len(input logic [3:0] w);
      logic [3:0] n;
      unique case (w)
         4'd0, 4'd2, 4'd6, 4'd7, 4'd8: n = 4'd4;
         4'd1:                         n = 4'd3;
         4'd3:                         n = 4'd8;
         4'd4, 4'd5:                   n = 4'd7;
         default:                      n = 4'd1;
      endcase
      return n;
   endfunction

   function automatic logic [63:0] word_str(input logic [3:0] w);
      logic [63:0] s;
      unique case (w)
         4'd0:    s = 64'("&tr=");
         4'd1:    s = 64'("udp");
         4'd2:    s = 64'("http");
         4'd3:    s = 64'("announce");
         4'd4:    s = 64'("torrent");
         4'd5:    s = 64'("tracker");
         4'd6:    s = 64'(".com");
         4'd7:    s = 64'(".org");
         4'd8:    s = 64'("open");
         default: s = 64'd0;
      endcase
      return s;
   endfunction

   // strings are right-justified, first character sits highest
   function automatic logic [7:0] word_char(input logic [3:0] w, input logic [2:0] i);
      logic [63:0] s;
      logic [3:0]  pos;
      s   = word_str(w);
      pos = word_len(w) - 4'd1 - {1'b0, i};
      return s[{pos[2:0], 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'd0, nib};
      end else begin
         c = CHAR_UPPER_A + {4'd0, nib} - 8'd10;
      end
      return c;
   endfunction

endpackage

### hdl/tud_ctrl.sv
module tud_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  tud_pkg::tud_stat_type stat,
   output tud_pkg::tud_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.emit  = (state_ff == ST_EMIT) && out_free;
      req_ready = (state_ff == ST_IDLE) || (cmd.emit && stat.last_result);
      cmd.take  = req_valid && req_ready;

      state_in = state_ff;
      if (cmd.emit && stat.last_result) begin
         state_in = ST_IDLE;
      end
      if (cmd.take && stat.has_output) begin
         state_in = ST_EMIT;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/tud_datapath.sv
module tud_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  tud_pkg::tud_cmd_type  cmd,
   output tud_pkg::tud_stat_type stat,
   input  logic [7:0]            req_code_byte,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_last_of_run,
   output logic                  rsp_string_end,
   output logic [7:0]            rsp_string_length,
   output logic                  rsp_overflow_error
);

   localparam int CW = tud_pkg::CNT_W;

   localparam logic [2:0] K_LIT  = 3'd0;
   localparam logic [2:0] K_ESC  = 3'd1;
   localparam logic [2:0] K_WORD = 3'd2;
   localparam logic [2:0] K_END  = 3'd3;
   localparam logic [2:0] K_ERR  = 3'd4;

   // string state
   logic [6:0]    esc_left_ff, esc_left_in;
   logic [CW-1:0] count_ff, count_in;
   logic          failed_ff, failed_in;

   // pending item
   logic [2:0] kind_ff, kind_in;
   logic [7:0] byte_ff;
   logic [3:0] num_ff, num_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] end_len_ff, end_len_in;
   logic       end_err_ff, end_err_in;

   // output word
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       end_ff, end_in;
   logic [7:0] len_ff, len_in;
   logic       err_ff, err_in;

   logic [3:0]    grp_len;
   logic [2:0]    grp_kind;
   logic          grp_check;
   logic          no_room;
   logic [CW:0]   sum;
   logic [3:0]    w;
   logic [CW+7:0] count_ext;

   assign w         = 4'(tud_pkg::WORD_LAST - req_code_byte);
   assign count_ext = (CW + 8)'(count_ff);

   always_comb begin
      grp_len   = 4'd1;
      grp_kind  = K_LIT;
      grp_check = 1'b0;
      if (esc_left_ff != 7'd0) begin
         grp_len   = 4'd3;
         grp_kind  = K_ESC;
         grp_check = !failed_ff;
      end else if (req_code_byte == 8'd0) begin
         grp_kind  = K_END;
      end else if (req_code_byte < tud_pkg::RUN_BASE) begin
         grp_check = !failed_ff;
      end else if (req_code_byte >= tud_pkg::WORD_FIRST) begin
         grp_len   = tud_pkg::word_len(w);
         grp_kind  = K_WORD;
         grp_check = !failed_ff;
      end
      sum     = (CW + 1)'(count_ff) + (CW + 1)'(grp_len);
      no_room = sum >= (CW + 1)'(tud_pkg::MAX_OUT_LEN);

      // status back to the sequencer
      stat.has_output  = (grp_kind == K_END) || grp_check;
      stat.last_result = ({1'b0, idx_ff} + 4'd1) == num_ff;
   end

   always_comb begin
      esc_left_in = esc_left_ff;
      count_in    = count_ff;
      failed_in   = failed_ff;
      kind_in     = kind_ff;
      num_in      = num_ff;
      end_len_in  = end_len_ff;
      end_err_in  = end_err_ff;

      if (esc_left_ff != 7'd0) begin
         esc_left_in = esc_left_ff - 7'd1;
      end else if (req_code_byte == 8'd0) begin
         count_in  = '0;
         failed_in = 1'b0;
      end else if (req_code_byte >= tud_pkg::RUN_BASE &&
                   req_code_byte < tud_pkg::WORD_FIRST) begin
         esc_left_in = req_code_byte[6:0];
      end

      if (grp_kind == K_END) begin
         kind_in    = K_END;
         num_in     = 4'd1;
         end_len_in = failed_ff ? 8'd0 : count_ext[7:0];
         end_err_in = failed_ff;
      end else if (grp_check) begin
         if (no_room) begin
            kind_in   = K_ERR;
            num_in    = 4'd1;
            failed_in = 1'b1;
         end else begin
            kind_in  = grp_kind;
            num_in   = grp_len;
            count_in = sum[CW-1:0];
         end
      end

      if (!cmd.take) begin
         esc_left_in = esc_left_ff;
         count_in    = count_ff;
         failed_in   = failed_ff;
         kind_in     = kind_ff;
         num_in      = num_ff;
         end_len_in  = end_len_ff;
         end_err_in  = end_err_ff;
      end
   end

   always_comb begin
      char_in = 8'd0;
      end_in  = 1'b0;
      len_in  = 8'd0;
      err_in  = 1'b0;
      last_in = stat.last_result;
      unique case (kind_ff)
         K_LIT:  char_in = byte_ff;
         K_ESC: begin
            unique case (idx_ff)
               3'd0:    char_in = tud_pkg::CHAR_PERCENT;
               3'd1:    char_in = tud_pkg::hex_char(byte_ff[7:4]);
               default: char_in = tud_pkg::hex_char(byte_ff[3:0]);
            endcase
         end
         K_WORD: char_in = tud_pkg::word_char(4'(tud_pkg::WORD_LAST - byte_ff), idx_ff);
         K_END: begin
            end_in = 1'b1;
            len_in = end_len_ff;
            err_in = end_err_ff;
         end
         default: err_in = 1'b1;
      endcase

      idx_in = idx_ff;
      if (cmd.emit) begin
         idx_in = idx_ff + 3'd1;
      end
      if (cmd.take) begin
         idx_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_left_ff <= 7'd0;
         count_ff    <= '0;
         failed_ff   <= 1'b0;
         num_ff      <= 4'd0;
         idx_ff      <= 3'd0;
      end else begin
         esc_left_ff <= esc_left_in;
         count_ff    <= count_in;
         failed_ff   <= failed_in;
         num_ff      <= num_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      end_len_ff <= end_len_in;
      end_err_ff <= end_err_in;
      if (cmd.take) begin
         byte_ff <= req_code_byte;
      end
      if (cmd.emit) begin
         char_ff <= char_in;
         last_ff <= last_in;
         end_ff  <= end_in;
         len_ff  <= len_in;
         err_ff  <= err_in;
      end
   end

   assign rsp_out_char       = char_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_string_end     = end_ff;
   assign rsp_string_length  = len_ff;
   assign rsp_overflow_error = err_ff;

endmodule

### hdl/tracker_url_decompressor.sv
// channel   direction  ports                                   meaning
// req       in         req_valid req_ready req_code_byte       one compressed code byte
// rsp       out        rsp_valid rsp_ready rsp_out_char        one expanded character,
//                      rsp_last_of_run rsp_string_end          end-of-string or error
//                      rsp_string_length rsp_overflow_error
//
// a byte is decoded in the cycle it is taken and yields 1 (literal, end, error),
// 3 (escape) or 3 to 8 (dictionary word) result words, loaded into the output
// register by the one-word-per-cycle emit sequencer while rsp is not stalled
// run openers and non-end bytes of a failed string make no words, taken every cycle
// the next byte is taken in the cycle the final word of the previous one is loaded
// synchronous active-high reset clears the string state and the output valid
// a stalled rsp holds the output register and the sequencer; req_ready stays low
// until the final word of the current byte is loaded
module tracker_url_decompressor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_code_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run,
   output logic       rsp_string_end,
   output logic [7:0] rsp_string_length,
   output logic       rsp_overflow_error
);

   // command and status between sequencer and datapath
   tud_pkg::tud_cmd_type  cmd;
   tud_pkg::tud_stat_type stat;

   // emit sequencer and output valid
   tud_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // decode, string state, pending item and output word
   tud_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_code_byte      (req_code_byte),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_string_end     (rsp_string_end),
      .rsp_string_length  (rsp_string_length),
      .rsp_overflow_error (rsp_overflow_error)
   );

   // the end word always closes its byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_last_of_run)
      else $error("end word without last_of_run");

   // an error word carries no character and closes its byte
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow_error && !rsp_string_end
         |-> rsp_out_char == 8'd0 && rsp_last_of_run)
      else $error("malformed error word");

   // length is reported only on the end word
   a_len_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_string_end |-> rsp_string_length == 8'd0)
      else $error("length outside end word");

endmodule
